/* sv/bimm_pkg.sv */
// shared types and constants of the boot info memory map parser
// no dependencies
package bimm_pkg;

  localparam int unsigned DEF_MAX_INFO_BYTES = 1048576;
  localparam logic [31:0] BOOT_MAGIC_VALUE   = 32'h36d76289;
  localparam logic [31:0] MIN_INFO_BYTES     = 32'd16;
  localparam logic [31:0] MAP_TAG_KIND       = 32'd6;
  localparam logic [31:0] MIN_ENTRY_SIZE     = 32'd24;
  localparam logic [7:0]  DEF_DISPLAY_LIMIT  = 8'd6;

  typedef enum logic [1:0] {
    CFG_BOOT_MAGIC    = 2'd0,
    CFG_INFO_ADDRESS  = 2'd1,
    CFG_DISPLAY_LIMIT = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } result_kind_t;

  typedef enum logic [3:0] {
    ERR_MAGIC     = 4'd0,
    ERR_UNALIGNED = 4'd1,
    ERR_SIZE      = 4'd2,
    ERR_SHORT_TAG = 4'd3,
    ERR_TAG_SIZE  = 4'd4,
    ERR_END_TAG   = 4'd5,
    ERR_MAP_TAG   = 4'd6,
    ERR_PADDING   = 4'd7,
    ERR_NO_END    = 4'd8,
    ERR_NO_MAP    = 4'd9
  } error_code_t;

  typedef struct packed {
    logic         start;
    logic         adv;
    logic         load_kind;
    logic         load_len;
    logic         use_word;
    logic         load_stride;
    logic         div_start;
    logic         set_map;
    logic         entry_step;
    logic         close_adv;
    logic         emit;
    result_kind_t kind;
    error_code_t  code;
  } bimm_cmd_t;

  typedef struct packed {
    logic magic_ok;
    logic align_ok;
    logic size_ok;
    logic at_tag;
    logic short_tag;
    logic tsize_bad;
    logic kind_zero;
    logic kind_map;
    logic word_eq8;
    logic word_lt16;
    logic map_seen;
    logic at_last;
    logic close_gt;
    logic close_eq;
    logic ver_bad;
    logic div_done;
    logic rem_zero;
    logic len_eq16;
    logic eo16;
    logic show_ok;
    logic slot_free;
  } bimm_status_t;

  function automatic logic [2:0] class_of(input logic [31:0] t);
    logic [2:0] c;
    unique case (t)
      32'd1:   c = 3'd0;
      32'd3:   c = 3'd1;
      32'd4:   c = 3'd2;
      32'd5:   c = 3'd3;
      default: c = 3'd4;
    endcase
    return c;
  endfunction

endpackage

/* sv/bimm_if.sv */
// channel interfaces: input words, results and register writes
// depends on nothing
interface bimm_in_if;
  logic        valid;
  logic        ready;
  logic        first_word;
  logic [31:0] info_word;
  modport source (output valid, first_word, info_word, input ready);
  modport sink   (input valid, first_word, info_word, output ready);
endinterface

interface bimm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  error_code;
  logic [15:0] entry_index;
  logic [63:0] region_base;
  logic [63:0] region_length;
  logic [31:0] region_type;
  logic [2:0]  region_class;
  logic [7:0]  shown_count;
  logic [15:0] entry_count;
  modport source (output valid, result_kind, error_code, entry_index, region_base,
                  region_length, region_type, region_class, shown_count, entry_count,
                  input ready);
  modport sink   (input valid, result_kind, error_code, entry_index, region_base,
                  region_length, region_type, region_class, shown_count, entry_count,
                  output ready);
endinterface

interface bimm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/bimm_ctrl.sv */
// parse controller: phase state machine issuing datapath commands
// depends on bimm_pkg
module bimm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_first,
  output logic                  in_ready,
  input  bimm_pkg::bimm_status_t st,
  output bimm_pkg::bimm_cmd_t    cmd
);
  import bimm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT_TAG, S_TAG_SIZE, S_SKIP, S_ESIZE, S_VER, S_DIV, S_ENTRY
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;
  logic   do_close;

  assign in_ready = st.slot_free && (state_r != S_DIV);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    do_close  = 1'b0;
    if (acc && in_first) begin
      cmd.start = 1'b1;
      priority if (!st.magic_ok) begin
        cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_MAGIC; state_nxt = S_IDLE;
      end else if (!st.align_ok) begin
        cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_UNALIGNED; state_nxt = S_IDLE;
      end else if (!st.size_ok) begin
        cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_SIZE; state_nxt = S_IDLE;
      end else begin
        state_nxt = S_WAIT_TAG;
      end
    end else if (acc) begin
      unique case (state_r)
        S_IDLE: begin
        end
        S_WAIT_TAG: begin
          cmd.adv = 1'b1;
          if (st.at_tag) begin
            if (st.short_tag) begin
              cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_SHORT_TAG;
              state_nxt = S_IDLE;
            end else begin
              cmd.load_kind = 1'b1;
              state_nxt = S_TAG_SIZE;
            end
          end
        end
        S_TAG_SIZE: begin
          cmd.adv      = 1'b1;
          cmd.load_len = 1'b1;
          cmd.use_word = 1'b1;
          priority if (st.tsize_bad) begin
            cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_TAG_SIZE;
            state_nxt = S_IDLE;
          end else if (st.kind_zero) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
            priority if (!st.word_eq8) begin
              cmd.kind = KIND_ERROR; cmd.code = ERR_END_TAG;
            end else if (!st.map_seen) begin
              cmd.kind = KIND_ERROR; cmd.code = ERR_NO_MAP;
            end else begin
              cmd.kind = KIND_SUMMARY;
            end
          end else if (st.kind_map && !st.map_seen) begin
            if (st.word_lt16) begin
              cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_MAP_TAG;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_ESIZE;
            end
          end else if (st.at_last) begin
            do_close = 1'b1;
          end else begin
            state_nxt = S_SKIP;
          end
        end
        S_SKIP: begin
          cmd.adv  = 1'b1;
          do_close = st.at_last;
        end
        S_ESIZE: begin
          cmd.adv         = 1'b1;
          cmd.load_stride = 1'b1;
          state_nxt       = S_VER;
        end
        S_VER: begin
          cmd.adv = 1'b1;
          if (st.ver_bad) begin
            cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_MAP_TAG;
            state_nxt = S_IDLE;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
        S_ENTRY: begin
          cmd.adv        = 1'b1;
          cmd.entry_step = 1'b1;
          if (st.at_last) begin
            do_close = 1'b1;
          end else if (st.eo16 && st.show_ok) begin
            cmd.emit = 1'b1; cmd.kind = KIND_ENTRY;
          end
        end
        S_DIV: begin
        end
        default: state_nxt = S_IDLE;
      endcase
    end else if (state_r == S_DIV && st.div_done && st.slot_free) begin
      if (!st.rem_zero) begin
        cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_MAP_TAG;
        state_nxt = S_IDLE;
      end else begin
        cmd.set_map = 1'b1;
        if (st.len_eq16) begin
          do_close = 1'b1;
        end else begin
          state_nxt = S_ENTRY;
        end
      end
    end

    if (do_close) begin
      priority if (st.close_gt) begin
        cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_PADDING;
        state_nxt = S_IDLE;
      end else if (st.close_eq) begin
        cmd.emit = 1'b1; cmd.kind = KIND_ERROR; cmd.code = ERR_NO_END;
        state_nxt = S_IDLE;
      end else begin
        cmd.close_adv = 1'b1;
        state_nxt     = S_WAIT_TAG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/bimm_dp.sv */
// parse datapath: config registers, offsets, entry assembly, remainder unit, result register
// depends on bimm_pkg
module bimm_dp #(
  parameter int unsigned MAX_INFO_BYTES = bimm_pkg::DEF_MAX_INFO_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [31:0]           word,
  input  bimm_pkg::bimm_cmd_t    cmd,
  output bimm_pkg::bimm_status_t st,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [1:0]            out_kind,
  output logic [3:0]            out_code,
  output logic [15:0]           out_index,
  output logic [63:0]           out_base,
  output logic [63:0]           out_length,
  output logic [31:0]           out_type,
  output logic [2:0]            out_class,
  output logic [7:0]            out_shown,
  output logic [15:0]           out_count
);
  import bimm_pkg::*;

  localparam int SW = $clog2(MAX_INFO_BYTES + 1) + 1;
  localparam int CW = $clog2(SW + 1);
  localparam logic [31:0] MAX_BYTES = 32'(MAX_INFO_BYTES);

  logic [31:0]   magic_r, addr_r;
  logic [7:0]    limit_r;
  logic [SW-1:0] boff_r, isize_r, toff_r, tlen_r, eoff_r;
  logic [31:0]   tkind_r, stride_r;
  logic          map_seen_r;
  logic [63:0]   base_r, len_r;
  logic [15:0]   seen_r;
  logic [7:0]    shown_r;
  logic [SW-1:0] dvd_r, rem_r;
  logic [CW-1:0] dcnt_r;

  logic [SW-1:0] room, tlen, last_word, rounded_lo;
  logic [SW:0]   rounded, eo_next;
  logic [32:0]   addr_sum, trial, stride33;
  logic          slot_free;

  // offset of the word that holds the tag's last byte, and padded tag size
  assign room       = isize_r - toff_r;
  assign tlen       = cmd.use_word ? word[SW-1:0] : tlen_r;
  assign last_word  = (toff_r + tlen - SW'(1)) & ~SW'(3);
  assign rounded    = ({1'b0, tlen} + (SW+1)'(7)) & ~(SW+1)'(7);
  assign rounded_lo = rounded[SW-1:0];
  assign addr_sum   = {1'b0, addr_r} + {1'b0, word};
  assign eo_next    = {1'b0, eoff_r} + (SW+1)'(4);
  assign stride33   = {1'b0, stride_r};
  assign trial      = 33'({rem_r, dvd_r[SW-1]});
  assign slot_free  = !out_valid || out_ready;

  always_comb begin
    st.magic_ok  = magic_r == BOOT_MAGIC_VALUE;
    st.align_ok  = addr_r[2:0] == 3'd0;
    st.size_ok   = !(word < MIN_INFO_BYTES || word > MAX_BYTES || addr_sum[32]);
    st.at_tag    = boff_r == toff_r;
    st.short_tag = room < SW'(8);
    st.tsize_bad = word < 32'd8 || word > 32'(room);
    st.kind_zero = tkind_r == 32'd0;
    st.kind_map  = tkind_r == MAP_TAG_KIND;
    st.word_eq8  = word == 32'd8;
    st.word_lt16 = word < 32'd16;
    st.map_seen  = map_seen_r;
    st.at_last   = last_word == boff_r;
    st.close_gt  = rounded > {1'b0, room};
    st.close_eq  = rounded == {1'b0, room};
    st.ver_bad   = word != 32'd0 || stride_r < MIN_ENTRY_SIZE || stride_r[2:0] != 3'd0;
    st.div_done  = dcnt_r == '0;
    st.rem_zero  = rem_r == '0;
    st.len_eq16  = tlen_r == SW'(16);
    st.eo16      = eoff_r == SW'(16);
    st.show_ok   = shown_r < limit_r;
    st.slot_free = slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r    <= '0;
      addr_r     <= '0;
      limit_r    <= DEF_DISPLAY_LIMIT;
      boff_r     <= '0;
      isize_r    <= '0;
      toff_r     <= '0;
      tlen_r     <= '0;
      tkind_r    <= '0;
      stride_r   <= '0;
      eoff_r     <= '0;
      map_seen_r <= 1'b0;
      seen_r     <= '0;
      shown_r    <= '0;
      dcnt_r     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BOOT_MAGIC:    magic_r <= cfg_data;
          CFG_INFO_ADDRESS:  addr_r  <= cfg_data;
          CFG_DISPLAY_LIMIT: limit_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        boff_r     <= SW'(4);
        isize_r    <= word[SW-1:0];
        toff_r     <= SW'(8);
        tkind_r    <= '0;
        tlen_r     <= '0;
        stride_r   <= '0;
        eoff_r     <= '0;
        map_seen_r <= 1'b0;
        seen_r     <= '0;
        shown_r    <= '0;
      end
      if (cmd.adv)         boff_r   <= boff_r + SW'(4);
      if (cmd.load_kind)   tkind_r  <= word;
      if (cmd.load_len)    tlen_r   <= word[SW-1:0];
      if (cmd.load_stride) stride_r <= word;
      if (cmd.close_adv)   toff_r   <= toff_r + rounded_lo;
      if (cmd.set_map) begin
        map_seen_r <= 1'b1;
        eoff_r     <= '0;
      end
      if (cmd.entry_step) begin
        eoff_r <= (33'(eo_next) >= stride33) ? '0 : eo_next[SW-1:0];
        if (st.eo16) begin
          seen_r <= seen_r + 16'd1;
          if (st.show_ok) shown_r <= shown_r + 8'd1;
        end
      end
      // restoring remainder, one dividend bit per cycle
      if (cmd.div_start) begin
        dcnt_r <= CW'(SW);
      end else if (dcnt_r != '0) begin
        dcnt_r <= dcnt_r - CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      base_r <= '0;
      len_r  <= '0;
    end
    if (cmd.entry_step) begin
      unique case (eoff_r)
        SW'(0):  base_r        <= {32'd0, word};
        SW'(4):  base_r[63:32] <= word;
        SW'(8):  len_r         <= {32'd0, word};
        SW'(12): len_r[63:32]  <= word;
        default: ;
      endcase
    end
    if (cmd.div_start) begin
      dvd_r <= tlen_r - SW'(16);
      rem_r <= '0;
    end else if (dcnt_r != '0) begin
      dvd_r <= {dvd_r[SW-2:0], 1'b0};
      rem_r <= (trial >= stride33) ? SW'(trial - stride33) : SW'(trial);
    end
    if (cmd.emit) begin
      out_kind   <= cmd.kind;
      out_code   <= (cmd.kind == KIND_ERROR) ? cmd.code : 4'd0;
      out_index  <= (cmd.kind == KIND_ENTRY) ? seen_r : 16'd0;
      out_base   <= (cmd.kind == KIND_ENTRY) ? base_r : 64'd0;
      out_length <= (cmd.kind == KIND_ENTRY) ? len_r : 64'd0;
      out_type   <= (cmd.kind == KIND_ENTRY) ? word : 32'd0;
      out_class  <= (cmd.kind == KIND_ENTRY) ? class_of(word) : 3'd0;
      out_shown  <= (cmd.kind == KIND_SUMMARY) ? shown_r : 8'd0;
      out_count  <= (cmd.kind == KIND_SUMMARY) ? seen_r : 16'd0;
    end
  end

endmodule

/* sv/boot_info_memory_map_parser.sv */
// boot information memory map parser, one 32-bit word per request
// result: registered on the word or remainder check behind it, shown in the cycle after
// throughput: one word per cycle while the result register is free; after a map tag
//   version word the input stalls while the remainder unit runs
// reset: synchronous active-low rst_n sets control state and config registers to defaults
module boot_info_memory_map_parser #(
  parameter int unsigned MAX_INFO_BYTES = bimm_pkg::DEF_MAX_INFO_BYTES
) (
  input logic    clk,
  input logic    rst_n,
  bimm_in_if.sink    in_ch,
  bimm_out_if.source out_ch,
  bimm_cfg_if.sink   cfg_ch
);
  import bimm_pkg::*;

  bimm_cmd_t    cmd;
  bimm_status_t st;

  // register writes are always taken
  assign cfg_ch.ready = 1'b1;

  // controller: phase tracking and result decisions
  bimm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_first (in_ch.first_word),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: offsets, checks, entry assembly, remainder unit and result register
  bimm_dp #(
    .MAX_INFO_BYTES (MAX_INFO_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .word       (in_ch.info_word),
    .cmd        (cmd),
    .st         (st),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_kind   (out_ch.result_kind),
    .out_code   (out_ch.error_code),
    .out_index  (out_ch.entry_index),
    .out_base   (out_ch.region_base),
    .out_length (out_ch.region_length),
    .out_type   (out_ch.region_type),
    .out_class  (out_ch.region_class),
    .out_shown  (out_ch.shown_count),
    .out_count  (out_ch.entry_count)
  );

endmodule

/* bench/bimm_map_monitor.sv */
`timescale 1ns / 1ps
// watches the word, register and result channels of the memory map parser
// predicts every result and compares it; needs bimm_pkg and the channel interfaces
module bimm_map_monitor (
  input  logic clk,
  input  logic rst_n,
  bimm_in_if   in_mon,
  bimm_out_if  out_mon,
  bimm_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);
  import bimm_pkg::*;

  localparam logic [31:0] INFO_LIMIT = DEF_MAX_INFO_BYTES;

  typedef enum logic [2:0] {
    WALK_IDLE, WALK_WAIT_TAG, WALK_TAG_SIZE, WALK_SKIP_BODY,
    WALK_MAP_ESIZE, WALK_MAP_VER, WALK_MAP_ENTRY
  } walk_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  code;
    logic [15:0] index;
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] rtype;
    logic [2:0]  rclass;
    logic [7:0]  shown;
    logic [15:0] total;
  } map_result_t;

  map_result_t result_q[$];

  logic [31:0] magic_reg, addr_reg;
  logic [7:0]  limit_reg;
  walk_phase_t ph;
  logic [31:0] boff, isize, tkind, tlen, toff, stride, eoff;
  logic        mseen;
  logic [63:0] bacc, lacc;
  logic [15:0] eseen;
  logic [7:0]  eshown;

  function automatic logic [2:0] region_class_of(input logic [31:0] t);
    case (t)
      32'd1:   return 3'd0;
      32'd3:   return 3'd1;
      32'd4:   return 3'd2;
      32'd5:   return 3'd3;
      default: return 3'd4;
    endcase
  endfunction

  task automatic push_error(input error_code_t c);
    map_result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.code = c;
    result_q.push_back(r);
    ph = WALK_IDLE;
  endtask

  task automatic close_tag();
    logic [31:0] rounded, room;
    rounded = (tlen + 32'd7) & ~32'd7;
    room = isize - toff;
    if (rounded > room) push_error(ERR_PADDING);
    else if (rounded == room) push_error(ERR_NO_END);
    else begin
      toff = toff + rounded;
      ph = WALK_WAIT_TAG;
    end
  endtask

  task automatic predict_word(input logic fw, input logic [31:0] word);
    logic [31:0] w, last;
    map_result_t r;
    if (fw) begin
      // a marked word restarts the walk from scratch
      ph = WALK_IDLE;
      boff = 4; mseen = 0; eseen = 0; eshown = 0;
      tkind = 0; tlen = 0; stride = 0; eoff = 0; bacc = 0; lacc = 0;
      if (magic_reg != BOOT_MAGIC_VALUE) push_error(ERR_MAGIC);
      else if (addr_reg[2:0] != 3'd0) push_error(ERR_UNALIGNED);
      else if (word < MIN_INFO_BYTES || word > INFO_LIMIT || addr_reg + word < addr_reg)
        push_error(ERR_SIZE);
      else begin
        isize = word;
        toff = 8;
        ph = WALK_WAIT_TAG;
      end
      return;
    end
    if (ph == WALK_IDLE) return;
    w = boff;
    boff = boff + 4;
    last = (toff + tlen - 32'd1) & ~32'd3;
    case (ph)
      WALK_WAIT_TAG: begin
        if (w != toff) return;
        if (isize - toff < 32'd8) push_error(ERR_SHORT_TAG);
        else begin
          tkind = word;
          ph = WALK_TAG_SIZE;
        end
      end
      WALK_TAG_SIZE: begin
        tlen = word;
        last = (toff + tlen - 32'd1) & ~32'd3;
        if (word < 32'd8 || word > isize - toff) push_error(ERR_TAG_SIZE);
        else if (tkind == 32'd0) begin
          if (word != 32'd8) push_error(ERR_END_TAG);
          else if (!mseen) push_error(ERR_NO_MAP);
          else begin
            r = '0;
            r.kind = KIND_SUMMARY;
            r.shown = eshown;
            r.total = eseen;
            result_q.push_back(r);
            ph = WALK_IDLE;
          end
        end else if (tkind == MAP_TAG_KIND && !mseen) begin
          if (word < 32'd16) push_error(ERR_MAP_TAG);
          else ph = WALK_MAP_ESIZE;
        end else if (last == w) close_tag();
        else ph = WALK_SKIP_BODY;
      end
      WALK_SKIP_BODY: if (last == w) close_tag();
      WALK_MAP_ESIZE: begin
        stride = word;
        ph = WALK_MAP_VER;
      end
      WALK_MAP_VER: begin
        if (word != 0 || stride < MIN_ENTRY_SIZE || stride[2:0] != 3'd0)
          push_error(ERR_MAP_TAG);
        else if ((tlen - 32'd16) % stride != 0) push_error(ERR_MAP_TAG);
        else begin
          mseen = 1;
          eoff = 0;
          if (tlen == 32'd16) close_tag();
          else ph = WALK_MAP_ENTRY;
        end
      end
      WALK_MAP_ENTRY: begin
        case (eoff)
          32'd0:  bacc = {32'd0, word};
          32'd4:  bacc[63:32] = word;
          32'd8:  lacc = {32'd0, word};
          32'd12: lacc[63:32] = word;
          32'd16: begin
            // entries past the display limit are only counted
            if (eshown < limit_reg) begin
              r = '0;
              r.kind = KIND_ENTRY;
              r.index = eseen;
              r.base = bacc;
              r.length = lacc;
              r.rtype = word;
              r.rclass = region_class_of(word);
              result_q.push_back(r);
              eshown = eshown + 8'd1;
            end
            eseen = eseen + 16'd1;
          end
          default: ;
        endcase
        eoff = eoff + 4;
        if (eoff >= stride) eoff = 0;
        if (last == w) close_tag();
      end
      default: ph = WALK_IDLE;
    endcase
  endtask

  task automatic compare_result();
    map_result_t got, want;
    got = '{out_mon.result_kind, out_mon.error_code, out_mon.entry_index,
            out_mon.region_base, out_mon.region_length, out_mon.region_type,
            out_mon.region_class, out_mon.shown_count, out_mon.entry_count};
    if (result_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result %h", got);
      return;
    end
    want = result_q.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("result mismatch kind %0d/%0d code %0d/%0d index %0d/%0d",
                 want.kind, got.kind, want.code, got.code, want.index, got.index);
        $display("  base %h/%h length %h/%h", want.base, got.base, want.length, got.length);
        $display("  type %h/%h class %0d/%0d shown %0d/%0d total %0d/%0d",
                 want.rtype, got.rtype, want.rclass, got.rclass,
                 want.shown, got.shown, want.total, got.total);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      magic_reg = 0; addr_reg = 0; limit_reg = DEF_DISPLAY_LIMIT;
      ph = WALK_IDLE; boff = 0; isize = 0; tkind = 0; tlen = 0; toff = 0;
      mseen = 0; stride = 0; eoff = 0; bacc = 0; lacc = 0; eseen = 0; eshown = 0;
      result_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) compare_result();
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_BOOT_MAGIC:    magic_reg = cfg_mon.data;
          CFG_INFO_ADDRESS:  addr_reg = cfg_mon.data;
          CFG_DISPLAY_LIMIT: limit_reg = cfg_mon.data[7:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_word(in_mon.first_word, in_mon.info_word);
    end
    pending = result_q.size();
  end

endmodule

/* bench/boot_info_memory_map_parser_tb.sv */
`timescale 1ns / 1ps
// stimulus and verdict for the boot information memory map parser
// needs bimm_pkg, the channel interfaces, the parser and bimm_map_monitor
module boot_info_memory_map_parser_tb;
  import bimm_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   calm;            // no idling on either side once set
  int   words_sent;
  logic [31:0] blob[$];  // one boot information structure, word 0 first
  int   ready_hold;

  bimm_in_if  in_ch ();
  bimm_out_if out_ch ();
  bimm_cfg_if cfg_ch ();

  boot_info_memory_map_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bimm_map_monitor mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // hard stop in case a handshake never completes
  initial begin
    #2000000;
    $display("FAIL boot_info_memory_map_parser");
    $finish;
  end

  // result side: random stall bursts until the quiet tail
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold--;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold = $urandom_range(1, 8) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one word request; valid stays high between back-to-back words
  task automatic send_word(input logic fw, input logic [31:0] w);
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.first_word <= fw;
    in_ch.info_word  <= w;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // registers change only with the parser drained; the extra cycles cover
  // words that are still in flight without a result
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_regs(input logic [31:0] magic, input logic [31:0] addr,
                          input logic [7:0] limit);
    settle();
    write_reg(CFG_BOOT_MAGIC, magic);
    write_reg(CFG_INFO_ADDRESS, addr);
    write_reg(CFG_DISPLAY_LIMIT, {24'd0, limit});
    // unknown index must be ignored
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
  endtask

  function automatic logic [31:0] pick_type(input int i, input bit rnd);
    logic [31:0] kinds[6];
    kinds = '{32'd1, 32'd3, 32'd4, 32'd5, 32'd2, 32'hffffffff};
    if (rnd && $urandom_range(0, 3) == 0) return $urandom;
    return kinds[i % 6];
  endfunction

  // builds plain tags, an optional map tag and an end tag, each padded to 8 bytes
  task automatic build_info(input int plain_tags, input bit with_map, input int stride,
                            input int entries, input bit rnd_types);
    int tl, pw;
    blob.delete();
    blob.push_back(0);
    blob.push_back($urandom);
    for (int t = 0; t < plain_tags; t++) begin
      tl = 8 + $urandom_range(0, 20);
      pw = ((tl + 7) & ~7) / 4;
      blob.push_back($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 20) | 1);
      blob.push_back(tl);
      for (int k = 2; k < pw; k++) blob.push_back($urandom);
    end
    if (with_map) begin
      blob.push_back(MAP_TAG_KIND);
      blob.push_back(16 + entries * stride);
      blob.push_back(stride);
      blob.push_back(0);
      for (int e = 0; e < entries; e++) begin
        for (int k = 0; k < 4; k++) blob.push_back($urandom);
        blob.push_back(pick_type(e, rnd_types));
        for (int k = 20; k < stride; k += 4) blob.push_back($urandom);
      end
    end
    blob.push_back(0);
    blob.push_back(8);
    blob[0] = blob.size() * 4;
  endtask

  // cut 0 sends all of it, otherwise the parse is abandoned after cut words
  task automatic send_info(input int cut);
    for (int i = 0; i < blob.size(); i++) begin
      if (cut != 0 && i >= cut) break;
      send_word(i == 0, blob[i]);
    end
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_word(1'b0, $urandom);
  endtask

  task automatic random_info();
    int mode, idx, strides[3];
    strides = '{24, 32, 40};
    build_info($urandom_range(0, 2), $urandom_range(0, 9) != 0, strides[$urandom_range(0, 2)],
               $urandom_range(0, 9), 1'b1);
    mode = $urandom_range(0, 11);
    idx = $urandom_range(1, blob.size() - 1);
    case (mode)
      6: blob[idx] = $urandom;
      7: blob[idx] = $urandom_range(0, 40);
      8: blob[0] = blob[0] + $urandom_range(0, 24) - 12;
      9: begin
        // end tag dropped, so the last tag ends exactly at the end of the structure
        void'(blob.pop_back());
        void'(blob.pop_back());
        blob[0] = blob.size() * 4;
      end
      10: blob[0] = $urandom_range(0, 3) == 0 ? $urandom : blob[0];
      default: ;
    endcase
    send_info(mode == 11 ? idx : 0);
    if ($urandom_range(0, 5) == 0) send_noise($urandom_range(1, 3));
  endtask

  initial begin
    calm = 0;
    words_sent = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_word = 1'b0;
    in_ch.info_word = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BOOT_MAGIC;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset magic is wrong, so the first structure is refused
    build_info(0, 1, 24, 1, 0);
    send_info(0);
    set_regs(BOOT_MAGIC_VALUE, 32'd0, DEF_DISPLAY_LIMIT);
    // every region class, a plain tag in front, then idle noise
    build_info(1, 1, 24, 6, 0);
    send_info(0);
    send_noise(2);
    // size below the minimum and above the maximum
    send_word(1'b1, 32'd15);
    send_word(1'b1, DEF_MAX_INFO_BYTES + 1);
    // empty map, then a structure with no map at all
    build_info(0, 1, 32, 0, 0);
    send_info(0);
    build_info(0, 0, 24, 0, 0);
    send_info(0);
    // restart in the middle of a map entry
    build_info(0, 1, 24, 2, 0);
    send_info(9);
    set_regs(BOOT_MAGIC_VALUE, 32'd4, 8'd0);
    send_word(1'b1, 32'd32);
    // base plus size wraps past the top of memory
    set_regs(BOOT_MAGIC_VALUE, 32'hfffffff0, 8'd255);
    send_word(1'b1, 32'd32);
    set_regs(BOOT_MAGIC_VALUE, 32'd0, 8'd0);
    build_info(0, 1, 24, 2, 0);
    send_info(0);
    set_regs(BOOT_MAGIC_VALUE, 32'hfffffff8, 8'd255);
    build_info(0, 1, 40, 1, 0);
    send_info(0);

    // random: well-formed and corrupted structures with random content
    for (int n = 0; words_sent < 560; n++) begin
      if (n % 8 == 7)
        set_regs($urandom_range(0, 7) == 0 ? $urandom : BOOT_MAGIC_VALUE,
                 $urandom_range(0, 7) == 0 ? $urandom :
                   {21'd0, 8'($urandom_range(0, 255)), 3'b000},
                 $urandom_range(0, 4) == 0 ? 8'd255 : 8'($urandom_range(0, 8)));
      if (words_sent > 450) calm = 1;
      random_info();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    calm = 1;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS boot_info_memory_map_parser");
    end else begin
      $display("FAIL boot_info_memory_map_parser");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bimm_pkg.sv
sv/bimm_if.sv
sv/bimm_ctrl.sv
sv/bimm_dp.sv
sv/boot_info_memory_map_parser.sv
bench/bimm_map_monitor.sv
bench/boot_info_memory_map_parser_tb.sv
